### src/dxt_pkg.sv
// Shared types, codes and divide helpers for the DXT block decoder.
`default_nettype none

package dxt_pkg;

    // Format register codes
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ALPHA_NONE     = 2'd0,
        ALPHA_EXPLICIT = 2'd1,
        ALPHA_INTERP   = 2'd2
    } alpha_mode_t;

    typedef struct packed {
        logic [63:0] color_block;
        logic [63:0] alpha_block;
    } dxt_in_t;

    typedef struct packed {
        logic [31:0] pixel_0;
        logic [31:0] pixel_1;
        logic [31:0] pixel_2;
        logic [31:0] pixel_3;
        logic [1:0]  row_index;
        logic        last_row;
    } dxt_out_t;

    // One classified block waiting for the row engine
    typedef struct packed {
        logic [3:0][31:0] pal;
        logic [7:0][7:0]  lvl;
        logic [31:0]      idx;
        logic [63:0]      ab;
        alpha_mode_t      mode;
    } dxt_job_t;

    // x / 3 for x < 768, by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[18:11];
    endfunction

    // x / 5 for x < 1280
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd3277;
        return p[21:14];
    endfunction

    // x / 7 for x < 1792
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd2341;
        return p[21:14];
    endfunction

endpackage

`default_nettype wire

### src/dxt_front.sv
// Front end: builds the colour palette and alpha levels for one block.
`default_nettype none

module dxt_front
    import dxt_pkg::*;
(
    input  var dxt_in_t  blk,
    input  var logic [1:0] format,
    output var dxt_job_t job
);

    logic [15:0] e0, e1;
    logic [7:0]  r0, g0, b0, r1, g1, b1;
    logic [7:0]  a0, a1;
    logic        four_color;

    assign e0 = blk.color_block[15:0];
    assign e1 = blk.color_block[31:16];
    assign r0 = {e0[15:11], 3'b000};
    assign g0 = {e0[10:5], 2'b00};
    assign b0 = {e0[4:0], 3'b000};
    assign r1 = {e1[15:11], 3'b000};
    assign g1 = {e1[10:5], 2'b00};
    assign b1 = {e1[4:0], 3'b000};
    assign a0 = blk.alpha_block[7:0];
    assign a1 = blk.alpha_block[15:8];
    assign four_color = (e0 > e1);

    // third-point blend: (2*x + y) / 3
    function automatic logic [7:0] third(input logic [7:0] x, input logic [7:0] y);
        return div3({1'b0, x, 1'b0} + {2'b00, y});
    endfunction

    // midpoint, truncated
    function automatic logic [7:0] half(input logic [7:0] x, input logic [7:0] y);
        logic [8:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[8:1];
    endfunction

    always_comb
    begin
        job.pal[0] = {8'hff, b0, g0, r0};
        job.pal[1] = {8'hff, b1, g1, r1};
        if (four_color)
        begin
            job.pal[2] = {8'hff, third(b0, b1), third(g0, g1), third(r0, r1)};
            job.pal[3] = {8'hff, third(b1, b0), third(g1, g0), third(r1, r0)};
        end
        else
        begin
            job.pal[2] = {8'hff, half(b0, b1), half(g0, g1), half(r0, r1)};
            // transparent key entry: r0 g255 b255 a0
            job.pal[3] = 32'h00ffff00;
        end

        job.lvl[0] = a0;
        job.lvl[1] = a1;
        if (a0 > a1)
        begin
            for (int c = 2; c < 8; c++)
            begin
                job.lvl[c] = div7(11'(8 - c) * 11'(a0) + 11'(c - 1) * 11'(a1));
            end
        end
        else
        begin
            for (int c = 2; c < 6; c++)
            begin
                job.lvl[c] = div5(11'(6 - c) * 11'(a0) + 11'(c - 1) * 11'(a1));
            end
            job.lvl[6] = 8'h00;
            job.lvl[7] = 8'hff;
        end

        case (format)
            FMT_DXT3: job.mode = ALPHA_EXPLICIT;
            FMT_DXT5: job.mode = ALPHA_INTERP;
            default:  job.mode = ALPHA_NONE;
        endcase

        job.idx = blk.color_block[63:32];
        job.ab  = blk.alpha_block;
    end

endmodule

`default_nettype wire

### src/dxt_queue.sv
// Two-entry job queue between the front end and the row engine.
`default_nettype none

module dxt_queue
    import dxt_pkg::*;
(
    input  var logic     clk,
    input  var logic     rst_n,
    input  var logic     push,
    input  var dxt_job_t push_job,
    output var logic     full,
    input  var logic     pop,
    output var logic     head_valid,
    output var dxt_job_t head_job
);

    dxt_job_t    mem_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign full       = (count_reg == 2'(QUEUE_DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### src/dxt_back.sv
// Row engine: emits one decoded row per cycle from the current job unless stalled.
`default_nettype none

module dxt_back
    import dxt_pkg::*;
(
    input  var logic     clk,
    input  var logic     rst_n,
    input  var logic     job_valid,
    input  var dxt_job_t job,
    output var logic     pop,
    output var logic     out_valid,
    input  var logic     out_stall,
    output var dxt_out_t out_data
);

    dxt_job_t    job_reg;
    logic        busy_reg, busy_next;
    logic [1:0]  row_reg, row_next;
    logic        out_valid_reg, out_valid_next;
    dxt_out_t    out_data_reg;
    logic        out_load, emit, finish, take;
    logic [3:0][31:0] row_px;

    assign out_load = !out_valid_reg || !out_stall;
    assign emit     = busy_reg && out_load;
    assign finish   = emit && (row_reg == 2'd3);
    assign take     = job_valid && (!busy_reg || finish);
    assign pop      = take;

    always_comb
    begin
        logic [3:0] k;
        logic [1:0] ci;
        logic [5:0] off;
        logic [3:0] nib;
        logic [2:0] code;
        for (int n = 0; n < 4; n++)
        begin
            k    = {row_reg, 2'(n)};
            ci   = job_reg.idx[{row_reg, 2'(n), 1'b0} +: 2];
            nib  = job_reg.ab[{k, 2'b00} +: 4];
            off  = 6'd16 + 6'(k) * 6'd3;
            code = job_reg.ab[off +: 3];
            row_px[n] = job_reg.pal[ci];
            case (job_reg.mode)
                ALPHA_EXPLICIT: row_px[n][31:24] = {nib, nib};
                ALPHA_INTERP:   row_px[n][31:24] = job_reg.lvl[code];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        busy_next      = take ? 1'b1 : (finish ? 1'b0 : busy_reg);
        row_next       = take ? 2'd0 : (emit ? row_reg + 2'd1 : row_reg);
        out_valid_next = emit ? 1'b1 : (out_load ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            row_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job;
        end
        if (emit)
        begin
            out_data_reg.pixel_0   <= row_px[0];
            out_data_reg.pixel_1   <= row_px[1];
            out_data_reg.pixel_2   <= row_px[2];
            out_data_reg.pixel_3   <= row_px[3];
            out_data_reg.row_index <= row_reg;
            out_data_reg.last_row  <= (row_reg == 2'd3);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### src/dxt_block_decompressor.sv
// Top level of the S3TC block decoder (DXT1 / DXT3 / DXT5).
//
//  channel | signals                     | item
//  --------+-----------------------------+-------------------------------------
//  in      | in_valid, in_stall, in_data | one 4x4 block: colour + alpha words
//  out     | out_valid, out_stall, out_data | one row: four pixels, row number
//  cfg     | cfg_we, cfg_data            | format (DXT1 / DXT3 / DXT5)
//
// Each block gives four row items, one per cycle unless out_stall holds the
// output; the row engine sets that rate. An accepted block is written to the
// queue, loaded as the row engine's job and passed row by row to the output
// register. A two-entry queue decouples the palette front end from the row
// engine; in_stall rises only when the queue is full.
// Reset clears control state and sets the format to DXT1.
// Format 3 decodes as DXT1. Write the format only while the block is idle.
`default_nettype none

module dxt_block_decompressor
    import dxt_pkg::*;
(
    input  var logic       clk,
    input  var logic       rst_n,
    input  var logic       in_valid,
    output var logic       in_stall,
    input  var dxt_in_t    in_data,
    output var logic       out_valid,
    input  var logic       out_stall,
    output var dxt_out_t   out_data,
    input  var logic       cfg_we,
    input  var logic [1:0] cfg_data
);

    logic [1:0] format_reg, format_next;
    dxt_job_t   front_job;
    dxt_job_t   head_job;
    logic       q_full, head_valid, pop;

    assign format_next = cfg_we ? cfg_data : format_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_DXT1;
        end
        else
        begin
            format_reg <= format_next;
        end
    end

    // palette, alpha levels and alpha mode for the incoming block
    dxt_front u_front (
        .blk    (in_data),
        .format (format_reg),
        .job    (front_job)
    );

    dxt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_job   (front_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    assign in_stall = q_full;

    // row-by-row pixel selection and output register
    dxt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
